// File: sv/brx_pkg.sv
package brx_pkg;

  // Field widths of the request and rectangle words.
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned COLOR_BITS = 16;
  localparam int unsigned SIZE_BITS  = COORD_BITS - 1;
  localparam int unsigned STYLE_BITS = 2;
  localparam int unsigned LEN_BITS   = 5;
  localparam int unsigned IDX_BITS   = 3;

  // Stream word layouts, padded with zeros up to whole bytes.
  localparam int unsigned IN_FIELD_BITS  = 4 * COORD_BITS + COLOR_BITS;
  localparam int unsigned IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int unsigned IN_USER_BITS   = 8;
  localparam int unsigned OUT_FIELD_BITS = 2 * COORD_BITS + 2 * SIZE_BITS + COLOR_BITS;
  localparam int unsigned OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // Arm length limits. A shorter side of ARM_SAT_MIN or more already gives
  // the upper limit, so the 30 percent product only runs on six bits.
  localparam int unsigned ARM_MIN     = 4;
  localparam int unsigned ARM_MAX     = 16;
  localparam int unsigned ARM_SAT_MIN = 54;
  // floor(p / 10) == (p * 205) >> 11 for every p below 1024.
  localparam int unsigned DIV10_MUL   = 205;
  localparam int unsigned DIV10_SHIFT = 11;

  // Request style codes.
  localparam logic [STYLE_BITS-1:0] STYLE_SHARP     = 2'd0;
  localparam logic [STYLE_BITS-1:0] STYLE_FILL      = 2'd1;
  localparam logic [STYLE_BITS-1:0] STYLE_BRACKET   = 2'd2;
  localparam logic [STYLE_BITS-1:0] STYLE_SHARP_ALT = 2'd3;

  typedef enum logic [1:0] {
    KIND_SHARP,
    KIND_FILL,
    KIND_BRACKET
  } kind_e;

  // Index of the final rectangle of each run.
  localparam logic [IDX_BITS-1:0] LAST_IDX_FILL    = 3'd0;
  localparam logic [IDX_BITS-1:0] LAST_IDX_SHARP   = 3'd3;
  localparam logic [IDX_BITS-1:0] LAST_IDX_BRACKET = 3'd7;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SIZE_BITS-1:0]  size_t;
  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic [LEN_BITS-1:0]   len_t;
  typedef logic [IDX_BITS-1:0]   idx_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] box_w;
    logic signed [COORD_BITS-1:0] box_h;
    color_t                       color;
    logic [STYLE_BITS-1:0]        style;
  } req_t;

  // Every corner coordinate a run can need, worked out once per request.
  typedef struct packed {
    kind_e  kind;
    coord_t x;
    coord_t y;
    coord_t xw1;   // x + w - 1
    coord_t xw2;   // x + w - 2
    coord_t xr;    // x + w - len
    coord_t yh1;   // y + h - 1
    coord_t yh2;   // y + h - 2
    coord_t yb;    // y + h - len
    size_t  w;
    size_t  h;
    len_t   len;
    color_t color;
  } geom_t;

  typedef struct packed {
    color_t color;
    size_t  h;
    size_t  w;
    coord_t y;
    coord_t x;
  } rect_t;

  function automatic idx_t last_idx(kind_e kind);
    idx_t r;
    case (kind)
      KIND_FILL:    r = LAST_IDX_FILL;
      KIND_BRACKET: r = LAST_IDX_BRACKET;
      default:      r = LAST_IDX_SHARP;
    endcase
    return r;
  endfunction

  // Bracket arm: 30 percent of the shorter side, clamped to 4..16 and then
  // to half of each side.
  function automatic len_t arm_len(size_t w, size_t h);
    size_t                 mn;
    logic [7:0]            p;
    logic [15:0]           prod;
    logic [LEN_BITS-1:0]   raw;
    logic [LEN_BITS-1:0]   r;
    mn = (w < h) ? w : h;
    p = 8'(mn[5:0]) * 8'd3;
    prod = 16'(p) * 16'(DIV10_MUL);
    if (mn >= SIZE_BITS'(ARM_SAT_MIN)) begin
      raw = LEN_BITS'(ARM_MAX);
    end else begin
      raw = LEN_BITS'(prod >> DIV10_SHIFT);
    end
    r = (raw < LEN_BITS'(ARM_MIN)) ? LEN_BITS'(ARM_MIN) : raw;
    if (SIZE_BITS'(r) > (w >> 1)) begin
      r = LEN_BITS'(w >> 1);
    end
    if (SIZE_BITS'(r) > (h >> 1)) begin
      r = LEN_BITS'(h >> 1);
    end
    return r;
  endfunction

endpackage

// File: sv/border_rect_expander_unit.sv
// Path: a request word passes the request register, the geometry register and the output
// register before its first rectangle word reaches the master side.
// Throughput: one rectangle word per cycle while the master side takes words; a request gives 1 (fill),
// 4 (sharp) or 8 (bracket) rectangle words, set by the run sequencer; an empty box gives none.
// Reset: rst_ni clears all valid flags and the run index at once; there is no clearing pass.
module border_rect_expander_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Request side.
  input  logic                                 s_tvalid_i,
  output logic                                 s_tready_o,
  // Fields from bit 0 up: pos_x, pos_y, box_w, box_h, color.
  input  logic [brx_pkg::IN_DATA_BITS-1:0]     s_tdata_i,
  // Fields from bit 0 up: style; upper bits unused.
  input  logic [brx_pkg::IN_USER_BITS-1:0]     s_tuser_i,
  // Rectangle side.
  output logic                                 m_tvalid_o,
  input  logic                                 m_tready_i,
  // Fields from bit 0 up: rect_x, rect_y, rect_w, rect_h, rect_color, zero padding.
  output logic [brx_pkg::OUT_DATA_BITS-1:0]    m_tdata_o,
  output logic                                 m_tlast_o
);
  import brx_pkg::*;

  // Stage one holds the raw request word.
  logic  s1_v_q, s1_v_d;
  req_t  s1_req_q;
  req_t  s_req;

  // Stage two holds the expanded geometry and walks through the run.
  logic  s2_v_q, s2_v_d;
  geom_t s2_geom_q;
  idx_t  idx_q, idx_d;

  // Output register separates the sequencer from the master side.
  logic  out_v_q, out_v_d;
  rect_t out_rect_q;
  logic  out_last_q;

  geom_t geom;
  logic  geom_empty;
  rect_t rect_sel;
  logic  s_fire;
  logic  out_free;
  logic  emit;
  logic  s2_last;
  logic  s2_free;
  logic  s1_move;
  logic  s2_load;

  // Unpack the request word.
  always_comb begin
    s_req.pos_x = s_tdata_i[COORD_BITS-1:0];
    s_req.pos_y = s_tdata_i[2*COORD_BITS-1:COORD_BITS];
    s_req.box_w = s_tdata_i[3*COORD_BITS-1:2*COORD_BITS];
    s_req.box_h = s_tdata_i[4*COORD_BITS-1:3*COORD_BITS];
    s_req.color = s_tdata_i[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];
    s_req.style = s_tuser_i[STYLE_BITS-1:0];
  end

  brx_geom u_geom (
    .req_i   (s1_req_q),
    .geom_o  (geom),
    .empty_o (geom_empty)
  );

  // The output register can take a new word when it is empty or its word is
  // being taken in this cycle. The sequencer frees up on the last word of its
  // run, so the next request moves in without a bubble.
  assign s_fire    = s_tvalid_i && s_tready_o;
  assign out_free  = !out_v_q || m_tready_i;
  assign emit      = s2_v_q && out_free;
  assign s2_last   = (idx_q == last_idx(s2_geom_q.kind));
  assign s2_free   = !s2_v_q || (emit && s2_last);
  assign s1_move   = s1_v_q && s2_free;
  assign s2_load   = s1_move && !geom_empty;
  assign s_tready_o = !s1_v_q || s2_free;

  // Pick the rectangle for the current run index.
  always_comb begin
    rect_sel.color = s2_geom_q.color;
    rect_sel.x     = s2_geom_q.x;
    rect_sel.y     = s2_geom_q.y;
    rect_sel.w     = s2_geom_q.w;
    rect_sel.h     = s2_geom_q.h;
    case (s2_geom_q.kind)
      KIND_FILL: begin
      end
      KIND_BRACKET: begin
        // Corner arms: horizontal one at even indexes, vertical one at odd.
        if (idx_q[0]) begin
          rect_sel.w = SIZE_BITS'(2);
          rect_sel.h = SIZE_BITS'(s2_geom_q.len);
          rect_sel.x = idx_q[1] ? s2_geom_q.xw2 : s2_geom_q.x;
          rect_sel.y = idx_q[2] ? s2_geom_q.yb  : s2_geom_q.y;
        end else begin
          rect_sel.w = SIZE_BITS'(s2_geom_q.len);
          rect_sel.h = SIZE_BITS'(2);
          rect_sel.x = idx_q[1] ? s2_geom_q.xr   : s2_geom_q.x;
          rect_sel.y = idx_q[2] ? s2_geom_q.yh2  : s2_geom_q.y;
        end
      end
      default: begin
        // Sharp outline: top and bottom edges, then left and right edges.
        if (idx_q[1]) begin
          rect_sel.w = SIZE_BITS'(1);
          rect_sel.x = idx_q[0] ? s2_geom_q.xw1 : s2_geom_q.x;
        end else begin
          rect_sel.h = SIZE_BITS'(1);
          rect_sel.y = idx_q[0] ? s2_geom_q.yh1 : s2_geom_q.y;
        end
      end
    endcase
  end

  always_comb begin
    s1_v_d = s1_v_q;
    if (s_fire) begin
      s1_v_d = 1'b1;
    end else if (s1_move) begin
      s1_v_d = 1'b0;
    end

    s2_v_d = s2_v_q;
    idx_d  = idx_q;
    if (s2_load) begin
      s2_v_d = 1'b1;
      idx_d  = '0;
    end else if (emit) begin
      idx_d = idx_q + IDX_BITS'(1);
      if (s2_last) begin
        s2_v_d = 1'b0;
      end
    end

    out_v_d = out_v_q;
    if (emit) begin
      out_v_d = 1'b1;
    end else if (m_tready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      idx_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      s2_v_q  <= s2_v_d;
      idx_q   <= idx_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_req_q <= s_req;
    end
    if (s2_load) begin
      s2_geom_q <= geom;
    end
    if (emit) begin
      out_rect_q <= rect_sel;
      out_last_q <= s2_last;
    end
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = OUT_DATA_BITS'(out_rect_q);
  assign m_tlast_o  = out_last_q;

  // The request side only stalls while both internal stages are occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> (s1_v_q && s2_v_q))
    else $error("request side stalled with a free stage");

  // The run index never passes the final rectangle of its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (idx_q <= last_idx(s2_geom_q.kind)))
    else $error("run index beyond end of run");

  // A new output word only appears when the sequencer held a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) |-> $past(s2_v_q))
    else $error("output word without an active run");

  // A filled box is a run of one, so its word always closes the run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (s2_geom_q.kind == KIND_FILL)) |=> m_tlast_o)
    else $error("filled box word not marked last");

endmodule

// File: sv/brx_geom.sv
module brx_geom (
  input  brx_pkg::req_t  req_i,
  output brx_pkg::geom_t geom_o,
  output logic           empty_o
);
  import brx_pkg::*;

  size_t  w;
  size_t  h;
  coord_t xw;
  coord_t yh;
  len_t   len;

  // A width or height of zero or below gives no rectangles.
  assign empty_o = req_i.box_w[COORD_BITS-1] || (req_i.box_w == '0) ||
                   req_i.box_h[COORD_BITS-1] || (req_i.box_h == '0);

  assign w   = req_i.box_w[SIZE_BITS-1:0];
  assign h   = req_i.box_h[SIZE_BITS-1:0];
  assign xw  = coord_t'(req_i.pos_x) + COORD_BITS'(w);
  assign yh  = coord_t'(req_i.pos_y) + COORD_BITS'(h);
  assign len = arm_len(w, h);

  always_comb begin
    geom_o.x     = coord_t'(req_i.pos_x);
    geom_o.y     = coord_t'(req_i.pos_y);
    geom_o.xw1   = xw - COORD_BITS'(1);
    geom_o.xw2   = xw - COORD_BITS'(2);
    geom_o.xr    = xw - COORD_BITS'(len);
    geom_o.yh1   = yh - COORD_BITS'(1);
    geom_o.yh2   = yh - COORD_BITS'(2);
    geom_o.yb    = yh - COORD_BITS'(len);
    geom_o.w     = w;
    geom_o.h     = h;
    geom_o.len   = len;
    geom_o.color = req_i.color;
    unique case (req_i.style) inside
      STYLE_FILL:                   geom_o.kind = KIND_FILL;
      STYLE_BRACKET:                geom_o.kind = KIND_BRACKET;
      STYLE_SHARP, STYLE_SHARP_ALT: geom_o.kind = KIND_SHARP;
      default:                      geom_o.kind = KIND_SHARP;
    endcase
  end

endmodule
